FILE: src/ntscap_pkg.sv
// ----------------------------------------------------------------------------
// ntscap_pkg
// Shared types, constants and helpers for the NTSC artifact pixel plotter.
// ----------------------------------------------------------------------------
package ntscap_pkg;

    localparam int HIST_BITS      = 12;
    localparam int PHASE_COUNT    = 4;
    localparam int PHASE_W        = $clog2(PHASE_COUNT);
    localparam int BITS_PER_GROUP = 14;
    localparam int FLUSH_PIXELS   = 4;
    localparam int ALPHA_SHIFT    = 24;
    localparam int TABLE_COUNT    = 2 + 2 * PHASE_COUNT;
    localparam int SEL_W          = 4;
    localparam int TBL_ADDR_W     = SEL_W + HIST_BITS;
    localparam int TBL_DEPTH      = TABLE_COUNT << HIST_BITS;
    localparam int CNT_W          = $clog2(BITS_PER_GROUP);
    localparam int PIX_W          = 32;
    localparam int PADDR_W        = 3;

    localparam logic [PADDR_W-1:0] ADDR_DISPLAY_MODE = 3'h0;
    localparam logic [PADDR_W-1:0] ADDR_ROW_DIM      = 3'h4;

    localparam logic [SEL_W-1:0] SEL_MONO_MON = 4'd0;
    localparam logic [SEL_W-1:0] SEL_MONO_TV  = 4'd1;
    localparam logic [SEL_W-1:0] SEL_CLR_MON  = 4'd2;
    localparam logic [SEL_W-1:0] SEL_CLR_TV   = SEL_W'(2 + PHASE_COUNT);
    localparam logic [SEL_W-1:0] SEL_LIMIT    = SEL_W'(TABLE_COUNT);

    typedef enum logic [1:0] {
        REQ_PLOT  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_MONO_MON = 2'd0,
        MODE_CLR_MON  = 2'd1,
        MODE_MONO_TV  = 2'd2,
        MODE_CLR_TV   = 2'd3
    } t_mode;

    typedef struct packed {
        logic                  en;
        logic [TBL_ADDR_W-1:0] addr;
    } t_tbl_rd;

    typedef struct packed {
        logic                  en;
        logic [TBL_ADDR_W-1:0] addr;
        logic [PIX_W-1:0]      data;
    } t_tbl_wr;

    function automatic logic [SEL_W-1:0] tbl_sel(input t_mode mode,
                                                 input logic [PHASE_W-1:0] phase);
        logic [SEL_W-1:0] sel;
        unique case (mode)
            MODE_MONO_MON: sel = SEL_MONO_MON;
            MODE_CLR_MON:  sel = SEL_CLR_MON + SEL_W'(phase);
            MODE_MONO_TV:  sel = SEL_MONO_TV;
            MODE_CLR_TV:   sel = SEL_CLR_TV + SEL_W'(phase);
            default:       sel = SEL_MONO_MON;
        endcase
        return sel;
    endfunction

    function automatic logic [PIX_W-1:0] half_pix(input logic [PIX_W-1:0] top,
                                                  input logic half_on);
        logic [PIX_W-1:0] dim;
        dim = ((top & 32'hFEFE_FEFE) >> 1) | (PIX_W'(8'hFF) << ALPHA_SHIFT);
        return half_on ? dim : top;
    endfunction

endpackage

FILE: src/ntscap_tbl.sv
// ----------------------------------------------------------------------------
// ntscap_tbl
// Color table store: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module ntscap_tbl
    import ntscap_pkg::*;
(
    input  logic             i_clk,
    input  t_tbl_wr          i_wr,
    input  t_tbl_rd          i_rd,
    output logic [PIX_W-1:0] o_rd_data
);

    logic [PIX_W-1:0] r_mem [0:TBL_DEPTH-1];
    logic [PIX_W-1:0] r_rd_data;

    // read returns old data on a same-cycle write to the same entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/ntsc_artifact_pixel_plotter.sv
// ----------------------------------------------------------------------------
// ntsc_artifact_pixel_plotter
// Signal bits to artifact-color pixels through history-indexed color tables.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: plot_bits, table_select,
//                                  table_index, table_data
// m_*      out  m_tvalid/m_tready  tdata: pixel_top, pixel_half; tlast: last
// apb      in   psel/penable       display_mode @0x0, row_dim @0x4
//
// One table read per pixel through the single read port sets the pace. Pixels
// leave through the table read register and then the output register. The next
// item is taken during the last pixel read of the current one. A stall on
// m_tready freezes the pixel pipe and the sequencer. No clearing pass after reset.
// ----------------------------------------------------------------------------
module ntsc_artifact_pixel_plotter
    import ntscap_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_tuser,   // [1:0] req_type
    input  logic [63:0]        s_tdata,   // [13:0] plot_bits, [17:14] table_select,
                                          // [29:18] table_index, [61:30] table_data
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,   // [31:0] pixel_top, [63:32] pixel_half
    output logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [BITS_PER_GROUP-1:0] in_bits;
    logic [SEL_W-1:0]          in_sel;
    logic [HIST_BITS-1:0]      in_idx;
    logic [PIX_W-1:0]          in_data;
    t_req                      in_req;

    t_mode                     r_mode;
    logic                      r_half;
    logic                      r_busy;
    logic                      r_flush;
    logic [CNT_W-1:0]          r_cnt;
    logic [BITS_PER_GROUP-1:0] r_bits;
    logic [HIST_BITS-1:0]      r_hist;
    logic [PHASE_W-1:0]        r_phase;
    logic                      r_p1_valid;
    logic                      r_p1_last;
    logic                      r_o_valid;
    logic                      r_o_last;
    logic [PIX_W-1:0]          r_o_top;
    logic [PIX_W-1:0]          r_o_half;

    logic                      w_adv;
    logic                      w_issue;
    logic                      w_fin;
    logic                      w_acc;
    logic                      w_cfg_wr;
    logic [HIST_BITS-1:0]      n_hist;
    logic [PHASE_W-1:0]        n_phase;
    logic [PIX_W-1:0]          rd_data;
    t_tbl_rd                   tbl_rd;
    t_tbl_wr                   tbl_wr;

    assign in_bits = s_tdata[13:0];
    assign in_sel  = s_tdata[17:14];
    assign in_idx  = s_tdata[29:18];
    assign in_data = s_tdata[61:30];
    assign in_req  = t_req'(s_tuser);

    always_comb begin
        w_adv    = !r_o_valid || m_tready;
        w_issue  = r_busy && w_adv;
        w_fin    = w_issue && (r_cnt == '0);
        s_tready = !r_busy || w_fin;
        w_acc    = s_tvalid && s_tready;
        n_hist   = {r_hist[HIST_BITS-2:0], r_bits[0]};
        n_phase  = (r_phase == PHASE_W'(PHASE_COUNT - 1)) ? '0 : r_phase + 1'b1;

        tbl_rd.en   = w_issue;
        tbl_rd.addr = {tbl_sel(r_mode, r_phase), n_hist};

        tbl_wr.en   = w_acc && (in_req == REQ_WRITE) && (in_sel < SEL_LIMIT);
        tbl_wr.addr = {in_sel, in_idx};
        tbl_wr.data = in_data;
    end

    ntscap_tbl u_tbl (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd      (tbl_rd),
        .o_rd_data (rd_data)
    );

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr)
            ADDR_DISPLAY_MODE: prdata = {30'd0, r_mode};
            ADDR_ROW_DIM:      prdata = {31'd0, r_half};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MONO_MON;
            r_half <= 1'b1;
        end else if (w_cfg_wr) begin
            if (paddr == ADDR_DISPLAY_MODE) begin
                r_mode <= t_mode'(pwdata[1:0]);
            end
            if (paddr == ADDR_ROW_DIM) begin
                r_half <= pwdata[0];
            end
        end
    end

    // sequencer: one pixel read per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_flush <= 1'b0;
            r_cnt   <= '0;
            r_hist  <= '0;
            r_phase <= '0;
        end else begin
            if (w_acc && (in_req == REQ_PLOT)) begin
                r_busy  <= 1'b1;
                r_flush <= 1'b0;
                r_cnt   <= CNT_W'(BITS_PER_GROUP - 1);
            end else if (w_acc && (in_req == REQ_FLUSH)) begin
                r_busy  <= 1'b1;
                r_flush <= 1'b1;
                r_cnt   <= CNT_W'(FLUSH_PIXELS - 1);
            end else if (w_issue) begin
                r_cnt <= r_cnt - 1'b1;
                if (w_fin) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_issue) begin
                if (w_fin && r_flush) begin
                    r_hist  <= '0;
                    r_phase <= '0;
                end else begin
                    r_hist  <= n_hist;
                    r_phase <= n_phase;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (in_req == REQ_PLOT)) begin
            r_bits <= in_bits;
        end else if (w_acc && (in_req == REQ_FLUSH)) begin
            r_bits <= '0;
        end else if (w_issue) begin
            r_bits <= r_bits >> 1;
        end
    end

    // pixel pipe: table read, then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_adv) begin
            r_p1_valid <= w_issue;
            r_o_valid  <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p1_last <= w_fin;
            r_o_last  <= r_p1_last;
            r_o_top   <= rd_data;
            r_o_half  <= half_pix(rd_data, r_half);
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {r_o_half, r_o_top};
    assign m_tlast  = r_o_last;

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && r_flush) |=> (r_hist == '0 && r_phase == '0))
        else $error("history or phase not cleared after flush");

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid && !w_adv) |=> (r_p1_valid && $stable(rd_data)))
        else $error("table read data lost during stall");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && r_cnt != '0) |=> r_busy)
        else $error("run ended early");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_W'(PHASE_COUNT - 1))
        else $error("phase out of range");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for ntsc_artifact_pixel_plotter. Request items go in on the
// slave stream in random bursts and pixels are taken off the master stream
// under a shifting ready pattern. A scoreboard model of the history, phase,
// color tables and display settings predicts every pixel. Color table entries
// are written before any plot can read them. Display settings are changed over
// APB between traffic phases and read back.
// ----------------------------------------------------------------------------
module tb;
    import ntscap_pkg::*;

    localparam int TBL_SPAN    = 1 << HIST_BITS;
    localparam int ITEM_TARGET = 370;
    localparam int N_SETTINGS  = 7;
    localparam int WDOG_LIMIT  = 2000;

    typedef struct packed {
        t_req        req;
        logic [13:0] bits;
        logic [3:0]  sel;
        logic [11:0] idx;
        logic [31:0] data;
        logic        fixed;
        logic [31:0] want_top;
        logic [31:0] want_half;
    } t_req_item;

    typedef struct packed {
        logic [31:0] top;
        logic [31:0] half;
        logic        last;
    } t_pix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [1:0]         s_tuser = '0;
    logic [63:0]        s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [63:0]        m_tdata;
    logic               m_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // scoreboard model state
    t_mode                mdl_mode = MODE_MONO_MON;
    logic                 mdl_half = 1'b1;
    logic [HIST_BITS-1:0] mdl_hist = '0;
    logic [PHASE_W-1:0]   mdl_phase = '0;
    logic [31:0]          color_mem [int];

    t_pix      pixel_q [$];
    t_req_item dir_tab [$];
    logic [13:0] bit_pool [8];

    t_mode cfg_mode [N_SETTINGS] = '{MODE_MONO_MON, MODE_CLR_MON, MODE_CLR_TV, MODE_MONO_TV,
                                     MODE_CLR_TV, MODE_CLR_MON, MODE_MONO_MON};
    logic  cfg_half [N_SETTINGS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    int   err_cnt = 0;
    int   items_sent = 0;
    int   pix_cnt = 0;
    int   burst_left = 0;
    int   idle_cnt = 0;
    int   rdy_mode = 0;
    int   rdy_left = 0;
    t_pix got_pix;
    t_pix want_pix;

    ntsc_artifact_pixel_plotter u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_err(input string msg);
        err_cnt++;
        if (err_cnt <= 40) begin
            $display("%0t tb mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int table_of(input t_mode mode, input logic [PHASE_W-1:0] ph);
        case (mode)
            MODE_CLR_MON: return int'(SEL_CLR_MON) + int'(ph);
            MODE_MONO_TV: return int'(SEL_MONO_TV);
            MODE_CLR_TV:  return int'(SEL_CLR_TV) + int'(ph);
            default:      return int'(SEL_MONO_MON);
        endcase
    endfunction

    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
        return PHASE_W'((int'(ph) + 1) % PHASE_COUNT);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic shade_pixel(input logic b, input logic last);
        int          key;
        logic [31:0] top;
        t_pix        p;
        key = table_of(mdl_mode, mdl_phase) * TBL_SPAN;
        mdl_hist = {mdl_hist[HIST_BITS-2:0], b};
        key = key + int'(mdl_hist);
        if (!color_mem.exists(key)) begin
            report_err($sformatf("plot reads unwritten table entry %0d", key));
            top = '0;
        end else begin
            top = color_mem[key];
        end
        p.top  = top;
        p.half = mdl_half ? (((top & 32'hFEFE_FEFE) >> 1) | (32'hFF << ALPHA_SHIFT)) : top;
        p.last = last;
        pixel_q.push_back(p);
        mdl_phase = next_phase(mdl_phase);
    endtask

    task automatic step_model(input t_req_item it, output int n);
        n = 0;
        case (it.req)
            REQ_PLOT: begin
                for (int i = 0; i < BITS_PER_GROUP; i++) begin
                    shade_pixel((i < 14) ? it.bits[i] : 1'b0, i == BITS_PER_GROUP - 1);
                end
                n = BITS_PER_GROUP;
            end
            REQ_WRITE: begin
                if (it.sel < SEL_LIMIT) begin
                    color_mem[int'(it.sel) * TBL_SPAN + int'(it.idx)] = it.data;
                end
                n = 0;
            end
            REQ_FLUSH: begin
                for (int i = 0; i < FLUSH_PIXELS; i++) begin
                    shade_pixel(1'b0, i == FLUSH_PIXELS - 1);
                end
                mdl_hist  = '0;
                mdl_phase = '0;
                n = FLUSH_PIXELS;
            end
            default: n = 0;
        endcase
    endtask

    task automatic send_item(input t_req_item it);
        int gap;
        int n;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= it.req;
        s_tdata  <= {2'b00, it.data, it.idx, it.sel, it.bits};
        do @(posedge i_clk); while (!s_tready);
        step_model(it, n);
        if (it.fixed) begin
            for (int k = pixel_q.size() - n; k < pixel_q.size(); k++) begin
                pixel_q[k].top  = it.want_top;
                pixel_q[k].half = it.want_half;
            end
        end
        if (it.req == REQ_PLOT || it.req == REQ_FLUSH
                || (it.req == REQ_WRITE && it.sel < SEL_LIMIT)) begin
            items_sent++;
        end
    endtask

    // write every table entry the coming pixels will read that holds nothing yet
    task automatic fill_tables(input logic [13:0] bits, input int npix);
        logic [HIST_BITS-1:0] h;
        logic [PHASE_W-1:0]   ph;
        int                   sel;
        t_req_item            w;
        h  = mdl_hist;
        ph = mdl_phase;
        for (int i = 0; i < npix; i++) begin
            h   = {h[HIST_BITS-2:0], (i < 14) ? bits[i] : 1'b0};
            sel = table_of(mdl_mode, ph);
            if (!color_mem.exists(sel * TBL_SPAN + int'(h))) begin
                w      = '0;
                w.req  = REQ_WRITE;
                w.sel  = SEL_W'(sel);
                w.idx  = h;
                w.data = rand_word();
                send_item(w);
            end
            ph = next_phase(ph);
        end
    endtask

    task automatic wait_drain(input int tail);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic apb_rw(input logic wr, input logic [PADDR_W-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: ready pattern switches among four characters at random
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(8, 60);
        end
        rdy_left--;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ((rdy_left % 12) >= 5);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got_pix = {m_tdata[31:0], m_tdata[63:32], m_tlast};
            if (pixel_q.size() == 0) begin
                report_err($sformatf("unexpected pixel %h", m_tdata));
            end else begin
                want_pix = pixel_q.pop_front();
                if (got_pix.top !== want_pix.top)
                    report_err($sformatf("pixel %0d top %h, want %h",
                                         pix_cnt, got_pix.top, want_pix.top));
                if (got_pix.half !== want_pix.half)
                    report_err($sformatf("pixel %0d half %h, want %h",
                                         pix_cnt, got_pix.half, want_pix.half));
                if (got_pix.last !== want_pix.last)
                    report_err($sformatf("pixel %0d tlast %b, want %b",
                                         pix_cnt, got_pix.last, want_pix.last));
            end
            pix_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                idle_cnt <= 0;
            end else if (idle_cnt >= WDOG_LIMIT) begin
                $display("tb: watchdog expired, %0d pixels outstanding", pixel_q.size());
                $display("tb: done, errors");
                $finish;
            end else begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

    initial begin
        t_req_item   it;
        logic [31:0] rd;
        int          r;

        dir_tab.push_back('{REQ_WRITE, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0000_0000,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_WRITE, 14'h0000, SEL_MONO_MON, 12'hFFF, 32'hFFFF_FFFF,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b1, 32'h0000_0000, 32'hFF00_0000});
        dir_tab.push_back('{REQ_RSVD, 14'h3FFF, 4'hF, 12'hFFF, 32'hFFFF_FFFF,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h3FFF, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h3FFF, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b1, 32'hFFFF_FFFF, 32'hFF7F_7F7F});
        dir_tab.push_back('{REQ_WRITE, 14'h0000, 4'hF, 12'h000, 32'h1234_5678,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_WRITE, 14'h0000, SEL_LIMIT, 12'hFFF, 32'h0000_0000,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_WRITE, 14'h0000, SEL_LIMIT - 4'd1, 12'hFFF, 32'hA5A5_A5A5,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_WRITE, 14'h0000, SEL_MONO_TV, 12'h000, 32'h8080_8080,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_FLUSH, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_FLUSH, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b1, 32'h0000_0000, 32'hFF00_0000});
        dir_tab.push_back('{REQ_PLOT, 14'h2AAA, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h1555, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h0001, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h2000, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_WRITE, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0102_0304,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_FLUSH, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b0, 32'h0, 32'h0});
        dir_tab.push_back('{REQ_PLOT, 14'h0000, SEL_MONO_MON, 12'h000, 32'h0,
                            1'b1, 32'h0102_0304, 32'hFF01_0102});

        bit_pool = '{14'h0000, 14'h3FFF, 14'h2AAA, 14'h1555, 14'($urandom),
                     14'($urandom), 14'($urandom), 14'($urandom)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p > 0) begin
                wait_drain(6);
                apb_rw(1'b1, ADDR_DISPLAY_MODE, 32'(cfg_mode[p]), rd);
                mdl_mode = cfg_mode[p];
                apb_rw(1'b1, ADDR_ROW_DIM, 32'(cfg_half[p]), rd);
                mdl_half = cfg_half[p];
                apb_rw(1'b0, ADDR_DISPLAY_MODE, 32'h0, rd);
                if (rd[1:0] !== mdl_mode)
                    report_err($sformatf("display_mode reads %h", rd));
                apb_rw(1'b0, ADDR_ROW_DIM, 32'h0, rd);
                if (rd[0] !== mdl_half)
                    report_err($sformatf("row_dim reads %h", rd));
            end else begin
                foreach (dir_tab[i]) begin
                    if (dir_tab[i].req == REQ_PLOT)
                        fill_tables(dir_tab[i].bits, BITS_PER_GROUP);
                    else if (dir_tab[i].req == REQ_FLUSH)
                        fill_tables(14'h0000, FLUSH_PIXELS);
                    send_item(dir_tab[i]);
                end
            end

            while (items_sent < (p + 1) * ITEM_TARGET / N_SETTINGS) begin
                r         = $urandom_range(0, 99);
                it        = '0;
                it.bits   = 14'($urandom);
                it.sel    = 4'($urandom);
                it.idx    = 12'($urandom);
                it.data   = rand_word();
                if (r < 60) begin
                    it.req = REQ_PLOT;
                    if ($urandom_range(0, 9) < 6)
                        it.bits = bit_pool[$urandom_range(0, 7)];
                    fill_tables(it.bits, BITS_PER_GROUP);
                    send_item(it);
                end else if (r < 72) begin
                    it.req = REQ_FLUSH;
                    fill_tables(14'h0000, FLUSH_PIXELS);
                    send_item(it);
                end else if (r < 88) begin
                    it.req = REQ_WRITE;
                    it.sel = SEL_W'($urandom_range(0, TABLE_COUNT - 1));
                    send_item(it);
                end else if (r < 93) begin
                    it.req = REQ_WRITE;
                    it.sel = SEL_W'($urandom_range(TABLE_COUNT, 15));
                    send_item(it);
                end else if (r < 97) begin
                    it.req = REQ_RSVD;
                    send_item(it);
                end else begin
                    wait_drain(2);
                end
            end
        end

        wait_drain(12);
        $display("tb: %0d items sent, %0d pixels checked", items_sent, pix_cnt);
        $display("tb: %0d display settings, both second-row modes, stalls on both sides",
                 N_SETTINGS);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: %0d mismatches", err_cnt);
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/ntscap_pkg.sv
src/ntscap_tbl.sv
src/ntsc_artifact_pixel_plotter.sv
dv/tb.sv
